// ===== rtl/box_filter_3x3_edge_normalized_unit_macros.svh =====
// ---------------------------------------------------------------------------
// Box filter 3x3 assertion macros
// Concurrent assertion wrappers; they compile to nothing for synthesis.
// ---------------------------------------------------------------------------
`ifndef BOX_FILTER_3X3_EDGE_NORMALIZED_UNIT_MACROS_SVH
`define BOX_FILTER_3X3_EDGE_NORMALIZED_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define BF3_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define BF3_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BF3_ASSERT_SAME(label, ante, cons, msg)
`define BF3_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ===== rtl/bf3_pkg.sv =====
// ---------------------------------------------------------------------------
// Box filter 3x3 package
// Shared widths, codes, control struct and the normalize reciprocal table.
// ---------------------------------------------------------------------------
package bf3_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int PIXEL_BITS_DEF = 16;

  localparam int DATA_BITS      = 16;  // pixel_value / filtered_value port width
  localparam int FW_BITS        = 11;  // frame_width register
  localparam int FH_BITS        = 13;  // frame_height register
  localparam int ROW_BITS       = 14;  // column-step row, runs up to height + 2
  localparam int CFG_INDEX_BITS = 1;
  localparam int CFG_DATA_BITS  = 13;

  localparam int CNT_BITS       = 4;   // neighbor count, 1..9
  localparam int RECIP_SHIFT    = 24;
  localparam int RECIP_BITS     = 25;

  localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_HEIGHT = 1'b1;

  typedef enum logic {
    FUNC_PIXEL = 1'b0,
    FUNC_DRAIN = 1'b1
  } func_t;

  typedef struct packed {
    logic load;  // capture window sum and count
    logic mul;   // multiply by reciprocal
  } norm_ctrl_t;

  // ceil(2^24 / n); exact truncated quotient for sums below 2^20
  function automatic logic [RECIP_BITS-1:0] recip(input logic [CNT_BITS-1:0] cnt);
    logic [RECIP_BITS-1:0] m;
    unique case (cnt)
      4'd1:    m = 25'd16777216;
      4'd2:    m = 25'd8388608;
      4'd3:    m = 25'd5592406;
      4'd4:    m = 25'd4194304;
      4'd6:    m = 25'd2796203;
      4'd9:    m = 25'd1864136;
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

// ===== rtl/bf3_ram.sv =====
// ---------------------------------------------------------------------------
// Box filter 3x3 generic RAM
// One write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module bf3_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/bf3_norm.sv =====
// ---------------------------------------------------------------------------
// Box filter 3x3 normalizer
// Divides the window sum by the in-frame neighbor count via reciprocal multiply.
// ---------------------------------------------------------------------------
module bf3_norm #(
  parameter int PIXEL_BITS = bf3_pkg::PIXEL_BITS_DEF
) (
  input  logic                    clk,
  input  bf3_pkg::norm_ctrl_t     ctrl,
  input  logic [PIXEL_BITS+3:0]   sum,
  input  logic [1:0]              nrow,
  input  logic [1:0]              ncol,
  output logic [PIXEL_BITS-1:0]   mean
);

  localparam int SUM_BITS  = PIXEL_BITS + 4;
  localparam int PROD_BITS = SUM_BITS + bf3_pkg::RECIP_BITS;

  logic [bf3_pkg::CNT_BITS-1:0]   cnt;
  logic [SUM_BITS-1:0]            sum_r;
  logic [bf3_pkg::RECIP_BITS-1:0] recip_r;
  logic [PROD_BITS-1:0]           prod_r;

  assign cnt = {2'b00, nrow} * {2'b00, ncol};

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      sum_r   <= sum;
      recip_r <= bf3_pkg::recip(cnt);
    end
    if (ctrl.mul) begin
      prod_r <= PROD_BITS'(sum_r) * PROD_BITS'(recip_r);
    end
  end

  assign mean = prod_r[bf3_pkg::RECIP_SHIFT +: PIXEL_BITS];

endmodule

// ===== rtl/box_filter_3x3_edge_normalized_unit.sv =====
// Result path: the releasing column step (read, WB), then SUM, MUL and OUT;
//   OUT waits while the output register holds an untaken result, then loads it.
// Each column step is a line-memory read-modify-write. A new request is taken only in
//   IDLE; the first drain request of a one-row frame runs extra column steps.
// Reset: counters, handshake state and output valid clear; width and height go to 1.
//   The line memory is not cleared: rows above the frame are masked, no clearing pass.
// ---------------------------------------------------------------------------
// Box filter 3x3 with edge normalization
// Streams a raster frame through a two-row line memory and emits the mean of
// the in-frame 3x3 neighbors, one row and one pixel behind the input.
// ---------------------------------------------------------------------------
`include "box_filter_3x3_edge_normalized_unit_macros.svh"

module box_filter_3x3_edge_normalized_unit #(
  parameter int MAX_WIDTH  = bf3_pkg::MAX_WIDTH_DEF,
  parameter int PIXEL_BITS = bf3_pkg::PIXEL_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [bf3_pkg::DATA_BITS-1:0]        in_tdata,   // [15:0] pixel_value
  input  logic                                 in_tuser,   // [0] func
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [bf3_pkg::DATA_BITS-1:0]        out_tdata,  // [15:0] filtered_value
  output logic                                 out_tlast,  // last_of_frame
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [bf3_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [bf3_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

  localparam int COL_BITS  = $clog2(MAX_WIDTH);
  localparam int WEFF_BITS = $clog2(MAX_WIDTH + 1);
  localparam int CS_BITS   = PIXEL_BITS + 2;
  localparam int SUM_BITS  = PIXEL_BITS + 4;
  localparam int ROW_BITS  = bf3_pkg::ROW_BITS;
  localparam int FH_BITS   = bf3_pkg::FH_BITS;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_RD   = 6'b000010,
    S_WB   = 6'b000100,
    S_SUM  = 6'b001000,
    S_MUL  = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  // configuration (effective values)
  logic [WEFF_BITS-1:0] w_r, w_nxt;
  logic [FH_BITS-1:0]   h_r, h_nxt;

  // column-step position and output position
  logic [ROW_BITS-1:0]  prow_r, prow_nxt;
  logic [COL_BITS-1:0]  pcol_r, pcol_nxt;
  logic [FH_BITS-1:0]   orow_r, orow_nxt;
  logic [COL_BITS-1:0]  ocol_r, ocol_nxt;

  // column step in flight
  logic [ROW_BITS-1:0]   trow_r;
  logic [COL_BITS-1:0]   tcol_r;
  logic [PIXEL_BITS-1:0] tpix_r;
  logic                  thas_r;

  // column sums: cs0 newest
  logic [CS_BITS-1:0] cs0_r, cs1_r, cs2_r;

  logic                            out_valid_r, out_valid_nxt;
  logic [bf3_pkg::DATA_BITS-1:0]   out_data_r;
  logic                            out_last_r;

  logic in_acc, cfg_acc, drain_ph, tick_go, issue, issue_pix;
  logic pc_last, c_last, r_last, fire, out_load, frame_last;
  logic [ROW_BITS-1:0] need_row;
  logic [COL_BITS-1:0] need_col;

  logic [bf3_pkg::FW_BITS-1:0] fw_in;
  logic [FH_BITS-1:0]          fh_in;

  logic                      ram_we, ram_re;
  logic [2*PIXEL_BITS-1:0]   ram_rdata, ram_wdata;
  logic [PIXEL_BITS-1:0]     rd_older, rd_newer;
  logic [CS_BITS-1:0]        colsum;

  logic [SUM_BITS-1:0]       win_sum;
  logic [1:0]                nrow, ncol;
  logic [PIXEL_BITS-1:0]     mean;
  bf3_pkg::norm_ctrl_t       norm_ctrl;

  assign in_acc    = in_tvalid && in_tready;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;

  assign drain_ph  = (prow_r >= ROW_BITS'(h_r));
  assign tick_go   = in_acc && (drain_ph || (in_tuser != bf3_pkg::FUNC_DRAIN));
  // a pixel request before the frame is complete steps its own column;
  // once complete, every request steps until its result is reached
  assign issue     = ((state_r == S_IDLE) && tick_go) || (state_r == S_RD);
  assign issue_pix = (state_r == S_IDLE) && !drain_ph;

  assign pc_last    = (WEFF_BITS'(pcol_r) == w_r - WEFF_BITS'(1));
  assign c_last     = (WEFF_BITS'(ocol_r) == w_r - WEFF_BITS'(1));
  assign r_last     = (orow_r == h_r - FH_BITS'(1));
  assign frame_last = c_last && r_last;

  // column step whose sum completes the current output's window
  assign need_row = ROW_BITS'(orow_r) + (c_last ? ROW_BITS'(2) : ROW_BITS'(1));
  assign need_col = c_last ? '0 : ocol_r + COL_BITS'(1);
  assign fire     = (state_r == S_WB) && (trow_r == need_row) && (tcol_r == need_col);

  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_tready);

  // line memory entry per column: upper half two rows back, lower half one row back
  assign ram_we    = (state_r == S_WB);
  assign ram_re    = issue;
  assign rd_older  = ram_rdata[2*PIXEL_BITS-1:PIXEL_BITS];
  assign rd_newer  = ram_rdata[PIXEL_BITS-1:0];
  assign ram_wdata = {rd_newer, tpix_r};

  bf3_ram #(
    .WIDTH (2 * PIXEL_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tcol_r),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (pcol_r),
    .rdata (ram_rdata)
  );

  // rows above the frame and below its last row drop out
  assign colsum = ((trow_r >= ROW_BITS'(2)) ? CS_BITS'(rd_older) : '0)
                + ((trow_r >= ROW_BITS'(1)) ? CS_BITS'(rd_newer) : '0)
                + (thas_r ? CS_BITS'(tpix_r) : '0);

  assign win_sum = ((ocol_r != '0) ? SUM_BITS'(cs2_r) : '0)
                 + SUM_BITS'(cs1_r)
                 + (!c_last ? SUM_BITS'(cs0_r) : '0);

  assign nrow = 2'd1 + 2'(orow_r != '0) + 2'(!r_last);
  assign ncol = 2'd1 + 2'(ocol_r != '0) + 2'(!c_last);

  assign norm_ctrl.load = (state_r == S_SUM);
  assign norm_ctrl.mul  = (state_r == S_MUL);

  bf3_norm #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_norm (
    .clk  (clk),
    .ctrl (norm_ctrl),
    .sum  (win_sum),
    .nrow (nrow),
    .ncol (ncol),
    .mean (mean)
  );

  // configuration decode
  assign fw_in = cfg_data[bf3_pkg::FW_BITS-1:0];
  assign fh_in = cfg_data[FH_BITS-1:0];

  always_comb begin
    w_nxt = w_r;
    h_nxt = h_r;
    if (cfg_acc) begin
      if (cfg_index == bf3_pkg::REG_FRAME_WIDTH) begin
        if (fw_in == '0) begin
          w_nxt = WEFF_BITS'(1);
        end else if (32'(fw_in) > 32'(MAX_WIDTH)) begin
          w_nxt = WEFF_BITS'(MAX_WIDTH);
        end else begin
          w_nxt = WEFF_BITS'(fw_in);
        end
      end else if (cfg_index == bf3_pkg::REG_FRAME_HEIGHT) begin
        h_nxt = (fh_in == '0) ? FH_BITS'(1) : fh_in;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (tick_go) state_nxt = S_WB;
      end
      S_RD:  state_nxt = S_WB;
      S_WB: begin
        if (fire) begin
          state_nxt = S_SUM;
        end else if (thas_r) begin
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_RD;
        end
      end
      S_SUM: state_nxt = S_MUL;
      S_MUL: state_nxt = S_OUT;
      S_OUT: begin
        if (out_load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    prow_nxt = prow_r;
    pcol_nxt = pcol_r;
    orow_nxt = orow_r;
    ocol_nxt = ocol_r;
    priority if (cfg_acc || (out_load && frame_last)) begin
      prow_nxt = '0;
      pcol_nxt = '0;
      orow_nxt = '0;
      ocol_nxt = '0;
    end else begin
      if (issue) begin
        if (pc_last) begin
          pcol_nxt = '0;
          prow_nxt = prow_r + ROW_BITS'(1);
        end else begin
          pcol_nxt = pcol_r + COL_BITS'(1);
        end
      end
      if (out_load) begin
        if (c_last) begin
          ocol_nxt = '0;
          orow_nxt = orow_r + FH_BITS'(1);
        end else begin
          ocol_nxt = ocol_r + COL_BITS'(1);
        end
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      w_r         <= WEFF_BITS'(1);
      h_r         <= FH_BITS'(1);
      prow_r      <= '0;
      pcol_r      <= '0;
      orow_r      <= '0;
      ocol_r      <= '0;
      thas_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      w_r         <= w_nxt;
      h_r         <= h_nxt;
      prow_r      <= prow_nxt;
      pcol_r      <= pcol_nxt;
      orow_r      <= orow_nxt;
      ocol_r      <= ocol_nxt;
      out_valid_r <= out_valid_nxt;
      if (issue) begin
        thas_r <= issue_pix;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      trow_r <= prow_r;
      tcol_r <= pcol_r;
      tpix_r <= in_tdata[PIXEL_BITS-1:0];
    end
    if (state_r == S_WB) begin
      cs0_r <= colsum;
      cs1_r <= cs0_r;
      cs2_r <= cs1_r;
    end
    if (out_load) begin
      out_data_r <= bf3_pkg::DATA_BITS'(mean);
      out_last_r <= frame_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  `BF3_ASSERT_SAME(a_ram_no_overlap, ram_we, !ram_re, "line memory read and write in one cycle")
  `BF3_ASSERT_NEXT(a_frame_end_clears, out_load && frame_last, (prow_r == '0) && (orow_r == '0) && (ocol_r == '0), "counters not cleared after last output")
  `BF3_ASSERT_SAME(a_ocol_in_frame, 1'b1, WEFF_BITS'(ocol_r) < w_r, "output column beyond frame width")

endmodule
